FILE: rtl/icc_pkg.sv
// shared constants, types and helper functions of the iteration count colormap
package icc_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int LIMIT_WIDTH     = 16;
  localparam int GAIN_WIDTH      = 4;
  localparam int LEVEL_WIDTH     = 8;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int POW_WIDTH       = 2;

  // linear scale is count * 2^24 / limit, quotient reaches 2^24
  localparam int LINEAR_SHIFT = 24;
  localparam int QUOT_WIDTH   = LINEAR_SHIFT + 1;
  // two quotient bits per divider stage
  localparam int DIV_STAGES   = LINEAR_SHIFT / 2;

  // polynomial has four factors, then the gain multiply
  localparam int POLY_STEPS  = 4;
  localparam int LANE_STAGES = POLY_STEPS + 1;

  // register reset values
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET      = 16'd256;
  localparam logic                   SMOOTH_RESET     = 1'b0;
  localparam logic [GAIN_WIDTH-1:0]  RED_GAIN_RESET   = 4'd9;
  localparam logic [GAIN_WIDTH-1:0]  GREEN_GAIN_RESET = 4'd15;
  localparam logic [GAIN_WIDTH-1:0]  BLUE_GAIN_RESET  = 4'd8;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_LIMIT      = 3'd0,
    CFG_SMOOTH     = 3'd1,
    CFG_PALETTE    = 3'd2,
    CFG_RED_GAIN   = 3'd3,
    CFG_GREEN_GAIN = 3'd4,
    CFG_BLUE_GAIN  = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    PAL_BLUE    = 2'd0,
    PAL_RED     = 2'd1,
    PAL_DEFAULT = 2'd2
  } palette_t;

  // number of t factors per channel
  typedef struct packed {
    logic [POW_WIDTH-1:0] red;
    logic [POW_WIDTH-1:0] green;
    logic [POW_WIDTH-1:0] blue;
  } powers_t;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] red;
    logic [LEVEL_WIDTH-1:0] green;
    logic [LEVEL_WIDTH-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] rem;
    logic                   qbit;
  } div_step_t;

  // palette code to per channel t powers, unused code falls to the default palette
  function automatic powers_t palette_powers(input logic [1:0] sel);
    powers_t pw;
    case (sel)
      PAL_BLUE: begin
        pw.red = 2'd3; pw.green = 2'd2; pw.blue = 2'd1;
      end
      PAL_RED: begin
        pw.red = 2'd1; pw.green = 2'd3; pw.blue = 2'd2;
      end
      default: begin
        pw.red = 2'd2; pw.green = 2'd1; pw.blue = 2'd3;
      end
    endcase
    return pw;
  endfunction

  // one restoring division step, remainder stays below the divisor
  function automatic div_step_t div_step(input logic [LIMIT_WIDTH-1:0] rem,
                                         input logic [LIMIT_WIDTH-1:0] divisor);
    logic [LIMIT_WIDTH:0] twice;
    logic [LIMIT_WIDTH:0] diff;
    div_step_t res;
    twice = {rem, 1'b0};
    diff  = twice - {1'b0, divisor};
    if (twice >= {1'b0, divisor}) begin
      res.rem  = diff[LIMIT_WIDTH-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = twice[LIMIT_WIDTH-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

FILE: rtl/icc_count_if.sv
// stream channel carrying one iteration count per transaction
interface icc_count_if #(
  parameter int COUNT_WIDTH = icc_pkg::COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

FILE: rtl/icc_color_if.sv
// stream channel carrying one rgb color per transaction
interface icc_color_if;
  logic                             valid;
  logic                             ready;
  logic [icc_pkg::LEVEL_WIDTH-1:0] red_level;
  logic [icc_pkg::LEVEL_WIDTH-1:0] green_level;
  logic [icc_pkg::LEVEL_WIDTH-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

FILE: rtl/icc_div.sv
// pipelined restoring divider computing count * 2^24 / limit, two bits per stage
module icc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [icc_pkg::LIMIT_WIDTH-1:0]     count,
  input  logic [icc_pkg::LIMIT_WIDTH-1:0]     limit,
  output logic                                out_valid,
  output logic [icc_pkg::QUOT_WIDTH-1:0]      quotient
);

  localparam int STAGES = icc_pkg::DIV_STAGES;
  localparam int QW     = icc_pkg::QUOT_WIDTH;

  logic [STAGES:0]                     vld;
  logic [icc_pkg::LIMIT_WIDTH-1:0]     rem [STAGES+1];
  logic [QW-1:0]                       quo [STAGES+1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:0], in_valid};
    end
  end

  // entry stage: count never exceeds limit, so the top quotient bit is count == limit
  always_ff @(posedge clk) begin
    if (en) begin
      if (count == limit) begin
        rem[0] <= '0;
        quo[0] <= QW'(1);
      end else begin
        rem[0] <= count;
        quo[0] <= '0;
      end
    end
  end

  // remaining quotient bits, two per stage
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    icc_pkg::div_step_t step_hi;
    icc_pkg::div_step_t step_lo;

    always_comb begin
      step_hi = icc_pkg::div_step(rem[s], limit);
      step_lo = icc_pkg::div_step(step_hi.rem, limit);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= step_lo.rem;
        quo[s+1] <= {quo[s][QW-3:0], step_hi.qbit, step_lo.qbit};
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign quotient  = quo[STAGES];

endmodule

FILE: rtl/icc_poly_lane.sv
// one color channel: gain * 255 * t^a * u^(4-a), one multiply per stage after the first
module icc_poly_lane #(
  parameter int FRACTION_BITS = icc_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [FRACTION_BITS:0]             t,
  input  logic [FRACTION_BITS:0]             u,
  input  logic [icc_pkg::POW_WIDTH-1:0]      tpow,
  input  logic [icc_pkg::GAIN_WIDTH-1:0]     gain,
  output logic [icc_pkg::LEVEL_WIDTH-1:0]    level
);

  localparam int PW    = FRACTION_BITS + 1;
  localparam int STEPS = icc_pkg::POLY_STEPS;
  localparam int GW    = icc_pkg::GAIN_WIDTH + icc_pkg::LEVEL_WIDTH;

  logic [PW-1:0] p  [STEPS];
  logic [PW-1:0] tq [STEPS-1];
  logic [PW-1:0] uq [STEPS-1];

  // first factor: p starts at one, so the product is the factor itself
  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= (tpow > icc_pkg::POW_WIDTH'(0)) ? t : u;
      tq[0] <= t;
      uq[0] <= u;
    end
  end

  // remaining factors, product truncated back to the fraction
  for (genvar i = 1; i < STEPS; i++) begin : g_step
    logic [PW-1:0]   factor;
    logic [2*PW-1:0] prod;

    always_comb begin
      factor = (tpow > icc_pkg::POW_WIDTH'(i)) ? tq[i-1] : uq[i-1];
      prod   = p[i-1] * factor;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p[i] <= prod[FRACTION_BITS +: PW];
      end
    end

    if (i < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          tq[i] <= tq[i-1];
          uq[i] <= uq[i-1];
        end
      end
    end
  end

  // gain * 255 scale, keep the low byte
  logic [GW-1:0]    gain_scale;
  logic [GW+PW-1:0] scaled;

  always_comb begin
    gain_scale = (GW'(gain) << icc_pkg::LEVEL_WIDTH) - GW'(gain);
    scaled     = gain_scale * p[STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level <= scaled[FRACTION_BITS +: icc_pkg::LEVEL_WIDTH];
    end
  end

endmodule

FILE: rtl/iteration_count_colormap_core.sv
// top level: iteration count to rgb colormap with config registers and output skid
//
// Usage: one escape-time iteration count enters on pixel_in per transaction and
// one rgb color leaves on color_out per transaction, in the same order. The
// count is saturated to iteration_limit (a limit of zero acts as one). Linear
// mode splits count * 2^24 / limit into blue, red and green bytes; smooth mode
// forms t = count / limit as a fraction and gives each channel a fourth order
// polynomial in t times gain * 255, wrapped to a byte.
// A color passes through 13 divider stages, 5 polynomial stages and the output
// register on its way from pixel_in to color_out.
// Throughput: one count per cycle while pixel_in.ready is high. Configuration must
// be written through cfg_write / cfg_index / cfg_data by the user while no
// transaction is in flight (unenforced); it takes effect for the following counts.
// Reset clears all valid bits and the skid entry and loads the register
// defaults: limit 256, linear mode, default palette, gains 9, 15, 8.
// When color_out stalls, the finished color waits in the output register, the
// next one goes to the skid entry, and only then pixel_in.ready drops and the
// whole pipeline holds.
module iteration_count_colormap_core #(
  parameter int COUNT_WIDTH   = icc_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = icc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  icc_count_if.sink                              pixel_in,
  icc_color_if.source                            color_out,
  input  logic                                   cfg_write,
  input  logic [icc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [icc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  localparam int LW         = icc_pkg::LIMIT_WIDTH;
  localparam int CMP_WIDTH  = (COUNT_WIDTH > LW) ? COUNT_WIDTH : LW;
  localparam int FRAC_SHIFT = icc_pkg::LINEAR_SHIFT - FRACTION_BITS;
  localparam int NST        = icc_pkg::LANE_STAGES;
  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // configuration registers
  logic [LW-1:0]                     iteration_limit;
  logic                              smooth_mode;
  logic [1:0]                        palette_select;
  logic [icc_pkg::GAIN_WIDTH-1:0]    red_gain;
  logic [icc_pkg::GAIN_WIDTH-1:0]    green_gain;
  logic [icc_pkg::GAIN_WIDTH-1:0]    blue_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= icc_pkg::LIMIT_RESET;
      smooth_mode     <= icc_pkg::SMOOTH_RESET;
      palette_select  <= icc_pkg::PAL_DEFAULT;
      red_gain        <= icc_pkg::RED_GAIN_RESET;
      green_gain      <= icc_pkg::GREEN_GAIN_RESET;
      blue_gain       <= icc_pkg::BLUE_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        icc_pkg::CFG_LIMIT:      iteration_limit <= cfg_data[LW-1:0];
        icc_pkg::CFG_SMOOTH:     smooth_mode     <= cfg_data[0];
        icc_pkg::CFG_PALETTE:    palette_select  <= cfg_data[1:0];
        icc_pkg::CFG_RED_GAIN:   red_gain        <= cfg_data[icc_pkg::GAIN_WIDTH-1:0];
        icc_pkg::CFG_GREEN_GAIN: green_gain      <= cfg_data[icc_pkg::GAIN_WIDTH-1:0];
        icc_pkg::CFG_BLUE_GAIN:  blue_gain       <= cfg_data[icc_pkg::GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: held only while the skid entry is occupied
  logic skid_valid;
  logic en;

  assign en             = ~skid_valid;
  assign pixel_in.ready = en;

  // saturate the count to the effective limit
  logic [LW-1:0]        limit_eff;
  logic [CMP_WIDTH-1:0] count_wide;
  logic [LW-1:0]        count_sat;

  always_comb begin
    limit_eff  = (iteration_limit == '0) ? LW'(1) : iteration_limit;
    count_wide = CMP_WIDTH'(pixel_in.iteration_count);
    count_sat  = (count_wide > CMP_WIDTH'(limit_eff)) ? limit_eff : LW'(count_wide);
  end

  // scaled count
  logic                              div_valid;
  logic [icc_pkg::QUOT_WIDTH-1:0]    quotient;

  icc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_in.valid),
    .count     (count_sat),
    .limit     (limit_eff),
    .out_valid (div_valid),
    .quotient  (quotient)
  );

  // smooth fraction and its complement
  logic [FRACTION_BITS:0] frac_t;
  logic [FRACTION_BITS:0] frac_u;
  icc_pkg::powers_t       powers;

  always_comb begin
    frac_t = quotient[FRAC_SHIFT +: FRACTION_BITS + 1];
    frac_u = ONE - frac_t;
    powers = icc_pkg::palette_powers(palette_select);
  end

  // polynomial lanes, one per channel
  icc_pkg::color_t lane_color;

  icc_poly_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_red (
    .clk (clk), .en (en), .t (frac_t), .u (frac_u),
    .tpow (powers.red), .gain (red_gain), .level (lane_color.red)
  );

  icc_poly_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_green (
    .clk (clk), .en (en), .t (frac_t), .u (frac_u),
    .tpow (powers.green), .gain (green_gain), .level (lane_color.green)
  );

  icc_poly_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_blue (
    .clk (clk), .en (en), .t (frac_t), .u (frac_u),
    .tpow (powers.blue), .gain (blue_gain), .level (lane_color.blue)
  );

  // linear value and valid bits alongside the lanes
  logic [NST-1:0]                    lane_vld;
  logic [icc_pkg::LINEAR_SHIFT-1:0]  lin [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= '0;
    end else if (en) begin
      lane_vld <= {lane_vld[NST-2:0], div_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= quotient[icc_pkg::LINEAR_SHIFT-1:0];
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_lin
    always_ff @(posedge clk) begin
      if (en) begin
        lin[k] <= lin[k-1];
      end
    end
  end

  // select the color of the finished item; bit 24 is dropped, so a full count wraps
  icc_pkg::color_t push_color;
  logic            push;

  always_comb begin
    push = en & lane_vld[NST-1];
    if (smooth_mode) begin
      push_color = lane_color;
    end else begin
      push_color.blue  = lin[NST-1][23:16];
      push_color.red   = lin[NST-1][15:8];
      push_color.green = lin[NST-1][7:0];
    end
  end

  // output register with one skid entry
  logic            out_valid;
  icc_pkg::color_t out_color;
  icc_pkg::color_t skid_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~out_valid | color_out.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (~out_valid | color_out.ready) begin
      out_color <= skid_valid ? skid_color : push_color;
    end else if (push) begin
      skid_color <= push_color;
    end
  end

  assign color_out.valid       = out_valid;
  assign color_out.red_level   = out_color.red;
  assign color_out.green_level = out_color.green;
  assign color_out.blue_level  = out_color.blue;

endmodule

FILE: verif/tb_iteration_count_colormap_core.sv
// self-checking testbench of the iteration count colormap core
`timescale 1ns / 100ps

module tb_iteration_count_colormap_core;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 24;
  localparam int PHASE_ITEMS   = 51;
  localparam int DIRECTED_N    = 26;
  localparam int FRAC_BITS     = icc_pkg::FRACTION_BITS_DEF;

  localparam logic        LINEAR_MODE  = 1'b0;
  localparam logic        SMOOTH_MODE  = 1'b1;
  localparam logic [1:0]  PAL_SPARE    = 2'd3;
  localparam logic [2:0]  CFG_SPARE_LO = 3'd6;
  localparam logic [2:0]  CFG_SPARE_HI = 3'd7;
  localparam logic [32:0] ONE_WIDE     = 33'h10000;
  localparam logic [16:0] ONE_FRAC     = 17'h10000;

  typedef struct packed {
    logic [15:0] limit;
    logic        smooth;
    logic [1:0]  palette;
    logic [3:0]  red_gain;
    logic [3:0]  green_gain;
    logic [3:0]  blue_gain;
  } colormap_setup_t;

  typedef struct packed {
    colormap_setup_t setup;
    logic [15:0]     count;
    logic            typed;
    icc_pkg::color_t color;
  } directed_row_t;

  localparam icc_pkg::color_t BLACK = '0;

  // register settings used by the directed rows
  localparam colormap_setup_t RESET_SETUP = '{icc_pkg::LIMIT_RESET, LINEAR_MODE,
      icc_pkg::PAL_DEFAULT, icc_pkg::RED_GAIN_RESET, icc_pkg::GREEN_GAIN_RESET,
      icc_pkg::BLUE_GAIN_RESET};
  localparam colormap_setup_t THIRDS_LIN  = '{16'd3, LINEAR_MODE, icc_pkg::PAL_DEFAULT,
      4'd9, 4'd15, 4'd8};
  localparam colormap_setup_t ZERO_LIN    = '{16'd0, LINEAR_MODE, icc_pkg::PAL_BLUE,
      4'd0, 4'd0, 4'd0};
  localparam colormap_setup_t WIDE_LIN    = '{16'hFFFF, LINEAR_MODE, icc_pkg::PAL_RED,
      4'hF, 4'hF, 4'hF};
  localparam colormap_setup_t SMOOTH_DEF  = '{icc_pkg::LIMIT_RESET, SMOOTH_MODE,
      icc_pkg::PAL_DEFAULT, icc_pkg::RED_GAIN_RESET, icc_pkg::GREEN_GAIN_RESET,
      icc_pkg::BLUE_GAIN_RESET};
  localparam colormap_setup_t SMOOTH_BLUE = '{16'd4, SMOOTH_MODE, icc_pkg::PAL_BLUE,
      4'hF, 4'hF, 4'hF};
  localparam colormap_setup_t SMOOTH_RED  = '{16'hFFFF, SMOOTH_MODE, icc_pkg::PAL_RED,
      4'hF, 4'hF, 4'hF};
  localparam colormap_setup_t SMOOTH_SPR  = '{16'd5, SMOOTH_MODE, PAL_SPARE,
      4'hF, 4'd0, 4'd7};
  localparam colormap_setup_t SMOOTH_MUTE = '{16'd7, SMOOTH_MODE, icc_pkg::PAL_DEFAULT,
      4'd0, 4'd0, 4'd0};
  localparam colormap_setup_t SMOOTH_ZERO = '{16'd0, SMOOTH_MODE, icc_pkg::PAL_RED,
      4'hF, 4'hF, 4'hF};

  // directed rows: typed colors where obvious, predictor otherwise
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{RESET_SETUP, 16'd0,     1'b1, BLACK},
    '{RESET_SETUP, 16'd1,     1'b1, '{8'h00, 8'h00, 8'h01}},
    '{RESET_SETUP, 16'd128,   1'b1, '{8'h00, 8'h00, 8'h80}},
    '{RESET_SETUP, 16'd255,   1'b1, '{8'h00, 8'h00, 8'hFF}},
    '{RESET_SETUP, 16'd256,   1'b1, BLACK},
    '{RESET_SETUP, 16'hFFFF,  1'b1, BLACK},
    '{THIRDS_LIN,  16'd1,     1'b1, '{8'h55, 8'h55, 8'h55}},
    '{THIRDS_LIN,  16'd2,     1'b1, '{8'hAA, 8'hAA, 8'hAA}},
    '{THIRDS_LIN,  16'hFFFF,  1'b1, BLACK},
    '{ZERO_LIN,    16'd0,     1'b1, BLACK},
    '{ZERO_LIN,    16'd1,     1'b1, BLACK},
    '{WIDE_LIN,    16'h8000,  1'b0, BLACK},
    '{WIDE_LIN,    16'hFFFE,  1'b0, BLACK},
    '{WIDE_LIN,    16'hFFFF,  1'b1, BLACK},
    '{SMOOTH_DEF,  16'd0,     1'b1, BLACK},
    '{SMOOTH_DEF,  16'd256,   1'b1, BLACK},
    '{SMOOTH_DEF,  16'd128,   1'b0, BLACK},
    '{SMOOTH_DEF,  16'd43,    1'b0, BLACK},
    '{SMOOTH_BLUE, 16'd1,     1'b0, BLACK},
    '{SMOOTH_BLUE, 16'd2,     1'b0, BLACK},
    '{SMOOTH_RED,  16'h8000,  1'b0, BLACK},
    '{SMOOTH_RED,  16'd1,     1'b0, BLACK},
    '{SMOOTH_SPR,  16'd2,     1'b0, BLACK},
    '{SMOOTH_SPR,  16'd3,     1'b0, BLACK},
    '{SMOOTH_MUTE, 16'd3,     1'b1, BLACK},
    '{SMOOTH_ZERO, 16'd1,     1'b1, BLACK}
  };

  logic clk = 1'b0;
  logic rst;
  logic                                cfg_write;
  logic [icc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [icc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

  icc_count_if #(.COUNT_WIDTH(icc_pkg::COUNT_WIDTH_DEF)) pixel_in ();
  icc_color_if color_out ();

  iteration_count_colormap_core dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .color_out (color_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  icc_pkg::color_t expected_colors [$];
  colormap_setup_t active_setup = RESET_SETUP;
  int              idle_max = 5;
  bit              pressure_armed = 1'b0;
  int              failures = 0;
  int              colors_checked = 0;
  int              linear_items = 0;
  int              smooth_items = 0;
  int              setups_applied = 1;
  int              cycle_count = 0;

  always #(HALF_PERIOD) clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d colors outstanding",
               $realtime, cycle_count, expected_colors.size());
      $display("tb: failure");
      $finish;
    end
  end

  // one channel byte: p = t^a * u^(4-a) in fixed point, then gain * 255, wrapped
  function automatic logic [7:0] shade_level(input logic [16:0] t_frac,
                                             input logic [16:0] u_frac,
                                             input int tpow,
                                             input logic [3:0] gain);
    logic [63:0] prod;
    prod = 64'd1 << FRAC_BITS;
    for (int k = 0; k < 4; k++)
      prod = (prod * ((k < tpow) ? 64'(t_frac) : 64'(u_frac))) >> FRAC_BITS;
    prod = (64'(gain) * 64'd255 * prod) >> FRAC_BITS;
    return prod[7:0];
  endfunction

  // color of one count under the given register setting
  function automatic icc_pkg::color_t predict_color(input colormap_setup_t s,
                                                    input logic [15:0] count);
    logic [15:0]     lim;
    logic [15:0]     cnt;
    logic [39:0]     scaled;
    logic [32:0]     frac;
    logic [16:0]     t_frac;
    logic [16:0]     u_frac;
    icc_pkg::color_t c;
    lim = (s.limit == 16'd0) ? 16'd1 : s.limit;
    cnt = (count > lim) ? lim : count;
    if (s.smooth == LINEAR_MODE) begin
      scaled  = {cnt, 24'd0} / {24'd0, lim};
      c.blue  = scaled[23:16];
      c.red   = scaled[15:8];
      c.green = scaled[7:0];
    end else begin
      frac = {1'b0, cnt, 16'd0} / {17'd0, lim};
      if (frac > ONE_WIDE) frac = ONE_WIDE;
      t_frac = frac[16:0];
      u_frac = ONE_FRAC - t_frac;
      case (s.palette)
        icc_pkg::PAL_BLUE: begin
          c.red   = shade_level(t_frac, u_frac, 3, s.red_gain);
          c.green = shade_level(t_frac, u_frac, 2, s.green_gain);
          c.blue  = shade_level(t_frac, u_frac, 1, s.blue_gain);
        end
        icc_pkg::PAL_RED: begin
          c.red   = shade_level(t_frac, u_frac, 1, s.red_gain);
          c.green = shade_level(t_frac, u_frac, 3, s.green_gain);
          c.blue  = shade_level(t_frac, u_frac, 2, s.blue_gain);
        end
        default: begin
          c.red   = shade_level(t_frac, u_frac, 2, s.red_gain);
          c.green = shade_level(t_frac, u_frac, 1, s.green_gain);
          c.blue  = shade_level(t_frac, u_frac, 3, s.blue_gain);
        end
      endcase
    end
    return c;
  endfunction

  // wait for every outstanding color, then for the pipeline to go quiet
  task automatic settle_pipeline();
    pixel_in.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write, write enable left high for the caller to drop
  task automatic cfg_put(input logic [2:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // drain, then load every register; unused upper data bits carry noise
  task automatic apply_settings(input colormap_setup_t s);
    settle_pipeline();
    cfg_put(icc_pkg::CFG_LIMIT, s.limit);
    cfg_put(icc_pkg::CFG_SMOOTH, {15'($urandom), s.smooth});
    cfg_put(icc_pkg::CFG_PALETTE, {14'($urandom), s.palette});
    cfg_put(icc_pkg::CFG_RED_GAIN, {12'($urandom), s.red_gain});
    cfg_put(icc_pkg::CFG_GREEN_GAIN, {12'($urandom), s.green_gain});
    cfg_put(icc_pkg::CFG_BLUE_GAIN, {12'($urandom), s.blue_gain});
    // writes to an unused index must leave everything alone
    cfg_put($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    cfg_write <= 1'b0;
    active_setup = s;
    setups_applied++;
  endtask

  // offer one count after a random gap, record its color once accepted
  task automatic send_count(input logic [15:0] count, input icc_pkg::color_t want);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      pixel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_in.valid           <= 1'b1;
    pixel_in.iteration_count <= count;
    @(posedge clk);
    while (pixel_in.ready !== 1'b1) @(posedge clk);
    expected_colors.push_back(want);
    if (active_setup.smooth == SMOOTH_MODE) smooth_items++;
    else linear_items++;
  endtask

  // color receiver: random stalls, one long hold when armed, field checks
  initial begin
    int              wait_cycles;
    icc_pkg::color_t got;
    icc_pkg::color_t want;
    color_out.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (pressure_armed) begin
        wait_cycles    = HOLD_CYCLES;
        pressure_armed = 1'b0;
      end else begin
        wait_cycles = $urandom_range(0, idle_max);
      end
      if (wait_cycles > 0) begin
        color_out.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      color_out.ready <= 1'b1;
      @(posedge clk);
      while (color_out.valid !== 1'b1) @(posedge clk);
      got = '{color_out.red_level, color_out.green_level, color_out.blue_level};
      if (expected_colors.size() == 0) begin
        $display("%0t unexpected color: expected none, actual %h/%h/%h",
                 $realtime, got.red, got.green, got.blue);
        failures++;
      end else begin
        want = expected_colors.pop_front();
        colors_checked++;
        if (got.red !== want.red) begin
          $display("%0t red_level mismatch: expected %h, actual %h",
                   $realtime, want.red, got.red);
          failures++;
        end
        if (got.green !== want.green) begin
          $display("%0t green_level mismatch: expected %h, actual %h",
                   $realtime, want.green, got.green);
          failures++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t blue_level mismatch: expected %h, actual %h",
                   $realtime, want.blue, got.blue);
          failures++;
        end
      end
    end
  end

  // stimulus: reset, directed table, then random phases
  initial begin
    colormap_setup_t s;
    logic [15:0]     lim_eff;
    logic [15:0]     cnt;
    int              pick;
    pixel_in.valid           <= 1'b0;
    pixel_in.iteration_count <= '0;
    cfg_write                <= 1'b0;
    cfg_index                <= icc_pkg::CFG_LIMIT;
    cfg_data                 <= '0;
    rst                      <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed rows, first ones under the reset register values
    for (int i = 0; i < DIRECTED_N; i++) begin
      if (DIRECTED_ROWS[i].setup != active_setup) apply_settings(DIRECTED_ROWS[i].setup);
      send_count(DIRECTED_ROWS[i].count,
                 DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].color
                                        : predict_color(active_setup, DIRECTED_ROWS[i].count));
    end

    // random phases, each with its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        s = '{16'hFFFF, SMOOTH_MODE, icc_pkg::PAL_BLUE, 4'hF, 4'hF, 4'hF};
      end else if (phase == 1) begin
        s = '{16'hFFFF, LINEAR_MODE, PAL_SPARE, 4'd0, 4'd0, 4'd0};
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       s.limit = 16'd0;
          1:       s.limit = 16'd1;
          2:       s.limit = 16'hFFFF;
          3, 4, 5, 6: s.limit = 16'($urandom_range(2, 16));
          7, 8:    s.limit = 16'($urandom_range(17, 1024));
          default: s.limit = 16'($urandom);
        endcase
        s.smooth     = ($urandom_range(0, 2) != 0) ? SMOOTH_MODE : LINEAR_MODE;
        s.palette    = 2'($urandom_range(0, 3));
        s.red_gain   = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom);
        s.green_gain = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom);
        s.blue_gain  = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom);
      end
      apply_settings(s);
      idle_max = (phase % 4 == 3) ? 0 : 5;
      // long output hold while counts keep coming, fills the pipeline
      if (phase == 5 || phase == 15) pressure_armed = 1'b1;
      lim_eff = (s.limit == 16'd0) ? 16'd1 : s.limit;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 8)       cnt = 16'($urandom_range(0, lim_eff));
        else if (pick < 11) cnt = 16'($urandom);
        else if (pick < 13) cnt = lim_eff;
        else if (pick < 15) cnt = 16'd0;
        else if (pick < 17) cnt = lim_eff - 16'd1;
        else                cnt = lim_eff + 16'd1;
        send_count(cnt, predict_color(active_setup, cnt));
      end
    end

    settle_pipeline();
    $display("summary: %0d colors checked, %0d linear and %0d smooth counts",
             colors_checked, linear_items, smooth_items);
    $display("summary: %0d register settings incl. zero and full limits, all palettes",
             setups_applied);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("%0t %0d mismatches", $realtime, failures);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/icc_pkg.sv
rtl/icc_count_if.sv
rtl/icc_color_if.sv
rtl/icc_div.sv
rtl/icc_poly_lane.sv
rtl/iteration_count_colormap_core.sv
verif/tb_iteration_count_colormap_core.sv
